// ===== rtl/ssi_pkg.sv =====
// shared constants, types and helpers of the sampled series interpolator
`timescale 1ns / 1ps
`default_nettype none
package ssi_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = 11;
   localparam int MAX_ORDER   = 8;
   localparam int ORDER_W     = 4;
   localparam int FRAC_BITS   = 16;
   localparam int ARG_W       = 28;
   localparam int VAL_W       = 32;
   localparam int MODE_W      = 2;
   localparam int IX_W        = ARG_W - FRAC_BITS;
   localparam int CMP_W       = IX_W + 1;
   localparam int MUL_W       = VAL_W + 1;
   localparam int PROD_W      = 64;
   localparam int ACC_W       = 52;
   localparam int QUO_W       = 48;
   localparam int DEN_W       = 4;
   localparam int DIV_STEPS   = 8;
   localparam int DIV_CYCLES  = QUO_W / DIV_STEPS;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);
   localparam logic [QUO_W-1:0]        WEIGHT_LIM = QUO_W'(64'd2147483647);
   localparam logic signed [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE    = 2'd0,
      MODE_LINEAR   = 2'd1,
      MODE_LAGRANGE = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LIN_A,
      ST_LIN_B,
      ST_ORD0,
      ST_NODE,
      ST_WEIGHT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SAMPLE,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              start;
      logic [QUO_W-1:0]  dividend;
      logic [DEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quotient;
   } div_rsp_type;

   // rescale a product by 2^FRAC_BITS, round half away from zero
   function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] q;
      mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      q   = (mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[PROD_W-1] ? -ACC_W'(q) : ACC_W'(q);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sampled_series_interpolator.sv =====
// top level: sample table, query sequencer, shared multiplier and divider
//
// usage
// - req channel (valid/ready) carries one item: mode 0 writes sample_value at
//   sample_index, mode 1 asks for a linear blend at argument, mode 2 asks for a
//   lagrange polynomial of the given order at argument; mode 3 is dropped
// - rsp channel (valid/ready) returns one item per query: result_value in
//   signed q16.16 and a saturated flag, none for writes
// - csr channel (valid/ready, always ready) sets series_length; write it only
//   while no query is in flight
// - a write leaves the block idle and req_ready stays high
// - a query holds req_ready low until its result sits in the output register;
//   queries use the one shared 33x33 multiplier, and lagrange queries use the
//   small divider once per basis factor
// - results wait in an output register, so the next item is taken while a
//   result is unread; a further finished query waits until rsp_ready
// - reset empties the output register, returns to idle and sets
//   series_length to 2; the table is not cleared and must be written first
`timescale 1ns / 1ps
`default_nettype none
module sampled_series_interpolator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic        [ssi_pkg::MODE_W-1:0] req_mode,
   input  wire logic        [ssi_pkg::ADDR_W-1:0] req_sample_index,
   input  wire logic signed [ssi_pkg::VAL_W-1:0]  req_sample_value,
   input  wire logic signed [ssi_pkg::ARG_W-1:0]  req_argument,
   input  wire logic        [ssi_pkg::ORDER_W-1:0] req_order,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed      [ssi_pkg::VAL_W-1:0]  rsp_result_value,
   output logic                                   rsp_saturated,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic        [ssi_pkg::LEN_W-1:0]  csr_series_length
);
   import ssi_pkg::*;

   // control state
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]      len_ff, len_in;

   // query payload
   logic signed [ARG_W-1:0] x_ff, x_in;
   logic [ORDER_W-1:0]    order_ff, order_in;
   logic                  is_lin_ff, is_lin_in;
   logic [ADDR_W-1:0]     lo_ff, lo_in;
   logic [ADDR_W-1:0]     hi_ff, hi_in;
   logic [ADDR_W-1:0]     i_ff, i_in;
   logic [ADDR_W-1:0]     m_ff, m_in;
   logic signed [VAL_W-1:0] w_ff, w_in;
   logic                  wneg_ff, wneg_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                  flag_ff, flag_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   // table port
   logic                  wr_en;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [VAL_W-1:0]      rd_data;

   // divider
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   // window setup
   logic [LEN_W-1:0]      n_used, last;
   logic [CMP_W-1:0]      ix, last_c, j_c, k_c, p_c, hi0;
   logic [ORDER_W-1:0]    ord_c;

   // shared multiplier
   logic signed [MUL_W-1:0]   mul_a, mul_b, diff;
   logic signed [2*MUL_W-1:0] mul_p;
   logic [ADDR_W-1:0]     node;

   // basis factor
   logic                  den_neg;
   logic [ADDR_W-1:0]     den_abs;
   logic [PROD_W-1:0]     prod_mag;
   logic [QUO_W-1:0]      qmag;
   logic signed [VAL_W-1:0] qval;
   logic signed [ACC_W-1:0] acc_sat;
   logic                  acc_over;

   assign wr_en     = req_valid && req_ready && (req_mode == MODE_WRITE);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   ssi_sample_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_sample_index),
      .wr_data (req_sample_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ssi_small_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // length in use and node window from the truncated argument
   always_comb begin
      if (len_ff < LEN_W'(2)) begin
         n_used = LEN_W'(2);
      end else if (len_ff > LEN_W'(TABLE_DEPTH)) begin
         n_used = LEN_W'(TABLE_DEPTH);
      end else begin
         n_used = len_ff;
      end
      last   = n_used - LEN_W'(1);
      last_c = CMP_W'(last);
      // negative arguments truncate to zero or below, both clamp to node 0
      ix     = x_ff[ARG_W-1] ? '0 : CMP_W'(x_ff[ARG_W-1:FRAC_BITS]);
      j_c    = (ix > last_c) ? last_c : ix;
      k_c    = (ix > last_c - CMP_W'(1)) ? last_c - CMP_W'(1) : ix;
      ord_c  = (order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_ff;
      p_c    = (CMP_W'(ord_c) > last_c) ? last_c : CMP_W'(ord_c);
      hi0    = j_c + CMP_W'(1) + (p_c >> 1);
   end

   // basis factor operands
   always_comb begin
      node    = (state_ff == ST_LIN_B) ? i_ff : m_ff;
      diff    = MUL_W'(x_ff) - $signed({{(MUL_W-ADDR_W-FRAC_BITS){1'b0}}, node,
                                        {FRAC_BITS{1'b0}}});
      den_neg = (i_ff < m_ff);
      den_abs = den_neg ? (m_ff - i_ff) : (i_ff - m_ff);
      prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      qmag    = (div_rsp.quotient > WEIGHT_LIM) ? WEIGHT_LIM : div_rsp.quotient;
      qval    = VAL_W'(qmag);
      acc_over = (acc_ff > ACC_MAX) || (acc_ff < ACC_MIN);
      if (acc_ff > ACC_MAX) begin
         acc_sat = ACC_MAX;
      end else if (acc_ff < ACC_MIN) begin
         acc_sat = ACC_MIN;
      end else begin
         acc_sat = acc_ff;
      end
   end

   assign mul_p = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      len_in       = len_ff;
      x_in         = x_ff;
      order_in     = order_ff;
      is_lin_in    = is_lin_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      m_in         = m_ff;
      w_in         = w_ff;
      wneg_in      = wneg_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      flag_in      = flag_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rd_en        = 1'b0;
      rd_addr      = i_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;

      if (csr_valid && csr_ready) begin
         len_in = csr_series_length;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_mode == MODE_LINEAR || req_mode == MODE_LAGRANGE)) begin
               x_in      = req_argument;
               order_in  = req_order;
               is_lin_in = (req_mode == MODE_LINEAR);
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            flag_in = 1'b0;
            acc_in  = '0;
            rd_en   = 1'b1;
            if (is_lin_ff) begin
               rd_addr  = ADDR_W'(k_c);
               i_in     = ADDR_W'(k_c);
               hi_in    = ADDR_W'(k_c);
               state_in = ST_LIN_A;
            end else if (p_c == '0) begin
               rd_addr  = ADDR_W'(j_c);
               state_in = ST_ORD0;
            end else begin
               rd_en = 1'b0;
               if (hi0 > last_c) begin
                  hi_in = ADDR_W'(last_c);
                  lo_in = ADDR_W'(last_c - p_c);
                  i_in  = ADDR_W'(last_c - p_c);
               end else if (hi0 < p_c) begin
                  hi_in = ADDR_W'(p_c);
                  lo_in = '0;
                  i_in  = '0;
               end else begin
                  hi_in = ADDR_W'(hi0);
                  lo_in = ADDR_W'(hi0 - p_c);
                  i_in  = ADDR_W'(hi0 - p_c);
               end
               state_in = ST_NODE;
            end
         end
         ST_LIN_A: begin
            // left sample into the accumulator, fetch the right one
            acc_in   = ACC_W'($signed(rd_data));
            rd_en    = 1'b1;
            rd_addr  = i_ff + ADDR_W'(1);
            state_in = ST_LIN_B;
         end
         ST_LIN_B: begin
            mul_a    = MUL_W'($signed(rd_data)) - MUL_W'($signed(acc_ff[VAL_W-1:0]));
            mul_b    = diff;
            prod_in  = PROD_W'(mul_p);
            state_in = ST_ACCUM;
         end
         ST_ORD0: begin
            acc_in   = ACC_W'($signed(rd_data));
            state_in = ST_FINISH;
         end
         ST_NODE: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            w_in     = ONE_FX;
            m_in     = lo_ff;
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            if (m_ff == i_ff) begin
               if (m_ff == hi_ff) begin
                  state_in = ST_SAMPLE;
               end else begin
                  m_in = m_ff + ADDR_W'(1);
               end
            end else begin
               mul_a    = MUL_W'(w_ff);
               mul_b    = diff;
               prod_in  = PROD_W'(mul_p);
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            // round(|w*diff| / (|i-m| * 2^f)) via a pre-shift then a small divide
            div_req.start    = 1'b1;
            div_req.dividend = QUO_W'((prod_mag + (PROD_W'(den_abs) << (FRAC_BITS - 1)))
                                      >> FRAC_BITS);
            div_req.divisor  = DEN_W'(den_abs);
            wneg_in          = prod_ff[PROD_W-1] ^ den_neg;
            state_in         = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient > WEIGHT_LIM) begin
                  flag_in = 1'b1;
               end
               w_in = wneg_ff ? -qval : qval;
               if (m_ff == hi_ff) begin
                  state_in = ST_SAMPLE;
               end else begin
                  m_in     = m_ff + ADDR_W'(1);
                  state_in = ST_WEIGHT;
               end
            end
         end
         ST_SAMPLE: begin
            mul_a    = MUL_W'($signed(rd_data));
            mul_b    = MUL_W'(w_ff);
            prod_in  = PROD_W'(mul_p);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            acc_in = acc_ff + round_frac(prod_ff);
            if (i_ff == hi_ff) begin
               state_in = ST_FINISH;
            end else begin
               i_in     = i_ff + ADDR_W'(1);
               state_in = ST_NODE;
            end
         end
         ST_FINISH: begin
            // hold here while the previous item is still unread
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = VAL_W'(acc_sat);
               rsp_sat_in   = flag_ff || acc_over;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= LEN_W'(2);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      order_ff     <= order_in;
      is_lin_ff    <= is_lin_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      m_ff         <= m_in;
      w_ff         <= w_in;
      wneg_ff      <= wneg_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      flag_ff      <= flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule
`default_nettype wire

// ===== rtl/ssi_sample_ram.sv =====
// sample table: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module ssi_sample_ram (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ssi_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [ssi_pkg::VAL_W-1:0]  wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ssi_pkg::ADDR_W-1:0] rd_addr,
   output logic      [ssi_pkg::VAL_W-1:0]  rd_data
);
   import ssi_pkg::*;

   logic [VAL_W-1:0] mem [TABLE_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/ssi_small_div.sv =====
// iterative divider by a small divisor, several quotient bits per cycle
`timescale 1ns / 1ps
`default_nettype none
module ssi_small_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ssi_pkg::div_req_type req,
   output ssi_pkg::div_rsp_type      rsp
);
   import ssi_pkg::*;

   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W-1:0]     rem_v;
   logic [QUO_W-1:0]     quo_v;
   logic [DEN_W:0]       trial;

   // restoring steps; remainder stays below the divisor
   always_comb begin
      rem_v = rem_ff;
      quo_v = quo_ff;
      trial = '0;
      for (int b = 0; b < DIV_STEPS; b++) begin
         trial = {rem_v, quo_v[QUO_W-1]};
         quo_v = {quo_v[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_v    = DEN_W'(trial - {1'b0, den_ff});
            quo_v[0] = 1'b1;
         end else begin
            rem_v = DEN_W'(trial);
         end
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_v;
         rem_in = rem_v;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/ssi_checker.sv =====
// port-level checks of the interpolator and their binding
`timescale 1ns / 1ps
`default_nettype none
module ssi_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic [ssi_pkg::MODE_W-1:0]  req_mode,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [ssi_pkg::VAL_W-1:0]   rsp_result_value,
   input wire logic                        rsp_saturated
);
   import ssi_pkg::*;

   // an unread item holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                  && $stable(rsp_saturated))
      else $error("rsp item changed while stalled");

   // a write item never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a write item");

   // a query occupies the block for at least the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_LINEAR || req_mode == MODE_LAGRANGE)
      |=> !req_ready)
      else $error("query accepted without going busy");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sampled_series_interpolator ssi_checker u_ssi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_saturated    (rsp_saturated)
);
`default_nettype wire
